FILE: rtl/cwfp_pkg.sv
// ----------------------------------------------------------------------------
// cwfp_pkg: shared types and constants of the cycle-walking Feistel permutation
// Holds the payload structs of the request and response channels, the
// register indexes of the configuration port, and the hash constants.
// ----------------------------------------------------------------------------
package cwfp_pkg;

    localparam int IDX_W       = 24;                 // index and result width
    localparam int CNT_W       = 25;                 // domain size register width
    localparam int HALF_W      = IDX_W / 2;          // widest Feistel half
    localparam int HB_W        = $clog2(HALF_W + 1); // holds a half width 0..HALF_W
    localparam int WORD_W      = 32;
    localparam int DATA_W      = 32;                 // configuration write data
    localparam int CFG_IDX_W   = 2;
    localparam int ROUND_COUNT = 4;
    localparam int RND_W       = $clog2(ROUND_COUNT);
    localparam int DIV_CNT_W   = $clog2(IDX_W);
    localparam int MAX_ITEMS   = 16777216;

    localparam logic [WORD_W-1:0] HASH_K1 = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] HASH_K2 = 32'h85EB_CA6B;
    localparam logic [WORD_W-1:0] HASH_K3 = 32'hC2B2_AE35;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ITEMS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED  = 2'd0,
        REG_EPOCH = 2'd1,
        REG_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             func;   // 0 forward, 1 inverse
        logic [IDX_W-1:0] index;
    } cwfp_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] mapped_index;
        logic             domain_fault;
    } cwfp_rsp_t;

endpackage

FILE: rtl/cycle_walking_feistel_permutation_top.sv
// ----------------------------------------------------------------------------
// cycle_walking_feistel_permutation_top: keyed permutation of 0..N-1
// Maps an index forward or back through a four-round Feistel network with
// cycle walking, built around one shared 32-bit multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg channel writes seed_word (index 0), epoch_number (index 1) and
//   item_count (index 2); cfg_ready is always high. Write it only while idle.
//   The req channel carries func and index; the rsp channel returns
//   mapped_index and domain_fault, one response per request.
//   One request is in flight at a time: req_ready is high only while the
//   sequencer is idle.
//   An index at or above N takes the bit-serial remainder path, one
//   quotient bit a cycle. N of one goes from the check straight to done.
//   Otherwise the request runs PRE0 to PRE2, then MIX and FOLD for each
//   round of a pass; cycle walking needs under four passes on average.
//   The response sits in an output register, so the next request is taken
//   while a stalled response waits; the sequencer only holds in its final
//   state if a second response is ready before the first is taken.
//   Reset clears all control state and loads seed 0, epoch 0, N = 1.
// ----------------------------------------------------------------------------
module cycle_walking_feistel_permutation_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cwfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cwfp_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  cwfp_pkg::cwfp_req_t           req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output cwfp_pkg::cwfp_rsp_t           rsp_data
);
    import cwfp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_PRE0  = 9'b000001000,
        S_PRE1  = 9'b000010000,
        S_PRE2  = 9'b000100000,
        S_MIX   = 9'b001000000,
        S_FOLD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUND_COUNT - 1);

    // Control state
    state_t                 state_reg, state_next;
    logic [WORD_W-1:0]      seed_reg;
    logic [WORD_W-1:0]      epoch_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [RND_W-1:0]       rcnt_reg, rcnt_next;
    logic [DIV_CNT_W-1:0]   dcnt_reg, dcnt_next;

    // Datapath
    logic                   func_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [HB_W-1:0]        hb_reg;
    logic [HALF_W-1:0]      mask_reg;
    logic [HALF_W-1:0]      lo_reg, lo_next;
    logic [HALF_W-1:0]      hi_reg, hi_next;
    logic [WORD_W-1:0]      mul_reg, mul_next;
    logic [WORD_W-1:0]      pre_reg, pre_next;
    logic [IDX_W-1:0]       rem_reg, rem_next;
    logic [IDX_W-1:0]       dvd_reg, dvd_next;
    logic [IDX_W-1:0]       res_reg, res_next;
    logic                   fault_reg, fault_next;
    cwfp_rsp_t              rsp_reg;

    // Combinational helpers
    logic [CNT_W-1:0]       n_eff;
    logic [IDX_W-1:0]       n_m1;
    logic [HB_W:0]          bit_len;
    logic [HB_W:0]          even_len;
    logic [HB_W-1:0]        hb_comb;
    logic [HALF_W-1:0]      mask_comb;
    logic [WORD_W-1:0]      mul_a, mul_b, mul_prod;
    logic [WORD_W-1:0]      mix_b, mix_c, fold_e;
    logic [HALF_W-1:0]      round_f;
    logic [HALF_W-1:0]      new_lo, new_hi;
    logic [IDX_W-1:0]       x_new;
    logic [CNT_W-1:0]       div_shift;
    logic [RND_W-1:0]       rcnt_inc;
    logic                   req_fire;
    logic                   out_free;

    function automatic logic [WORD_W-1:0] round_value(input logic [RND_W-1:0] r,
                                                      input logic inv);
        logic [RND_W-1:0] v;
        v = inv ? (LAST_RND - r) : r;
        return {{(WORD_W-RND_W){1'b0}}, v};
    endfunction

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Domain size with zero and oversize counts clamped.
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (count_reg > MAX_COUNT)
        begin
            n_eff = MAX_COUNT;
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    // Bit length of N-1, rounded up to even, gives twice the half width.
    always_comb
    begin
        n_m1    = IDX_W'(n_eff - CNT_W'(1));
        bit_len = '0;
        for (int i = 0; i < IDX_W; i++)
        begin
            if (n_m1[i])
            begin
                bit_len = (HB_W+1)'(i + 1);
            end
        end
        even_len  = bit_len + (HB_W+1)'(bit_len[0]);
        hb_comb   = even_len[HB_W:1];
        mask_comb = HALF_W'(({{(HALF_W){1'b0}}, 1'b1} << hb_comb) - 1'b1);
    end

    // Shared multiplier operand selection; only the low word is kept.
    always_comb
    begin
        mix_b = mul_reg + {{(WORD_W-HALF_W){1'b0}}, (func_reg ? lo_reg : hi_reg)};
        mix_c = mix_b ^ (mix_b >> 16);
        mul_a = seed_reg;
        mul_b = HASH_K1;
        unique case (state_reg)
            S_PRE0:
            begin
                mul_a = seed_reg;
                mul_b = HASH_K1;
            end
            S_PRE1:
            begin
                mul_a = mul_reg + epoch_reg;
                mul_b = HASH_K2;
            end
            S_PRE2:
            begin
                mul_a = pre_reg + round_value('0, func_reg);
                mul_b = HASH_K3;
            end
            S_MIX:
            begin
                mul_a = mix_c;
                mul_b = HASH_K2;
            end
            S_FOLD:
            begin
                mul_a = pre_reg + round_value(rcnt_inc, func_reg);
                mul_b = HASH_K3;
            end
            default:
            begin
                mul_a = seed_reg;
                mul_b = HASH_K1;
            end
        endcase
        mul_prod = mul_a * mul_b;
    end

    // Round fold: finish the hash and swap the halves.
    always_comb
    begin
        rcnt_inc = (rcnt_reg == LAST_RND) ? '0 : rcnt_reg + 1'b1;
        fold_e   = mul_reg ^ (mul_reg >> 13);
        round_f  = fold_e[HALF_W-1:0] & mask_reg;
        if (func_reg)
        begin
            new_lo = hi_reg ^ round_f;
            new_hi = lo_reg;
        end
        else
        begin
            new_hi = lo_reg ^ round_f;
            new_lo = hi_reg;
        end
        x_new     = (IDX_W'(new_hi) << hb_reg) | IDX_W'(new_lo);
        div_shift = {rem_reg, dvd_reg[IDX_W-1]};
    end

    always_comb
    begin
        state_next     = state_reg;
        rcnt_next      = rcnt_reg;
        dcnt_next      = dcnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mul_next       = mul_reg;
        pre_next       = pre_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        res_next       = res_reg;
        fault_next     = fault_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                lo_next   = idx_reg[HALF_W-1:0] & mask_comb;
                hi_next   = HALF_W'(idx_reg >> hb_comb) & mask_comb;
                rem_next  = '0;
                dvd_next  = idx_reg;
                dcnt_next = '0;
                if ({1'b0, idx_reg} >= n_eff)
                begin
                    fault_next = 1'b1;
                    state_next = S_DIV;
                end
                else if (n_eff == CNT_W'(1))
                begin
                    fault_next = 1'b0;
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    fault_next = 1'b0;
                    state_next = S_PRE0;
                end
            end
            S_DIV:
            begin
                // Restoring remainder, one dividend bit per cycle.
                if (div_shift >= n_reg)
                begin
                    rem_next = IDX_W'(div_shift - n_reg);
                end
                else
                begin
                    rem_next = div_shift[IDX_W-1:0];
                end
                dvd_next  = dvd_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(IDX_W - 1))
                begin
                    res_next   = rem_next;
                    state_next = S_DONE;
                end
            end
            S_PRE0:
            begin
                mul_next   = mul_prod;
                state_next = S_PRE1;
            end
            S_PRE1:
            begin
                pre_next   = mul_prod;
                state_next = S_PRE2;
            end
            S_PRE2:
            begin
                mul_next   = mul_prod;
                rcnt_next  = '0;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                mul_next   = mul_prod;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                // The first hash product of the next round is started here.
                mul_next  = mul_prod;
                lo_next   = new_lo;
                hi_next   = new_hi;
                rcnt_next = rcnt_inc;
                if (rcnt_reg == LAST_RND && {1'b0, x_new} < n_reg)
                begin
                    res_next   = x_new;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MIX;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rcnt_reg      <= '0;
            dcnt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            seed_reg      <= '0;
            epoch_reg     <= '0;
            count_reg     <= CNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            rcnt_reg      <= rcnt_next;
            dcnt_reg      <= dcnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEED:  seed_reg  <= cfg_data;
                    REG_EPOCH: epoch_reg <= cfg_data;
                    REG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg <= req_data.func;
            idx_reg  <= req_data.index;
        end
        if (state_reg == S_CHECK)
        begin
            n_reg    <= n_eff;
            hb_reg   <= hb_comb;
            mask_reg <= mask_comb;
        end
        if (state_reg == S_DONE && out_free)
        begin
            rsp_reg.mapped_index <= res_reg;
            rsp_reg.domain_fault <= fault_reg;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mul_reg   <= mul_next;
        pre_reg   <= pre_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        res_reg   <= res_next;
        fault_reg <= fault_next;
    end

    // A fresh response always lies inside the domain of its request.
    a_rsp_in_domain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> ({1'b0, rsp_data.mapped_index} < n_reg))
        else $error("response index outside the domain");

    // The partial remainder never reaches the divisor.
    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < n_reg))
        else $error("partial remainder not reduced");

    // Feistel halves stay within the half width of the domain.
    a_halves_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX || state_reg == S_FOLD) |->
            ((lo_reg & ~mask_reg) == '0 && (hi_reg & ~mask_reg) == '0))
        else $error("Feistel half wider than the half width");

    // The first pass of the network starts at the first round.
    a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRE2) |=> (rcnt_reg == '0 && state_reg == S_MIX))
        else $error("network pass did not start at round zero");

endmodule

FILE: tb/sv/cycle_walking_feistel_permutation_checker.sv
// ----------------------------------------------------------------------------
// cycle_walking_feistel_permutation_checker: scoreboard for the permutation
// Watches the configuration, request and response channels, keeps its own
// copy of the key registers, predicts the image of every accepted request
// and compares each accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module cycle_walking_feistel_permutation_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cwfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cwfp_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  cwfp_pkg::cwfp_req_t            req_data,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  cwfp_pkg::cwfp_rsp_t            rsp_data,
    output int                             fail_count,
    output int                             pending
);
    import cwfp_pkg::*;

    logic [WORD_W-1:0] seed_key;
    logic [WORD_W-1:0] epoch_key;
    logic [CNT_W-1:0]  domain_reg;
    cwfp_rsp_t         expected_maps[$];
    cwfp_rsp_t         oldest_map;
    int                errors;

    function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] rnd,
                                                    input logic [WORD_W-1:0] half);
        logic [WORD_W-1:0] h;
        h = seed_key;
        h = h * HASH_K1 + epoch_key;
        h = h * HASH_K2 + rnd;
        h = h * HASH_K3 + half;
        h = h ^ (h >> 16);
        h = h * HASH_K2;
        h = h ^ (h >> 13);
        return h;
    endfunction

    // One full pass of the Feistel network over a value of 2*hb bits.
    function automatic logic [WORD_W-1:0] feistel_pass(input logic [WORD_W-1:0] x,
                                                       input int hb,
                                                       input logic inverse);
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] f;
        mask = (32'd1 << hb) - 32'd1;
        lo   = x & mask;
        hi   = (x >> hb) & mask;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            if (!inverse)
            begin
                f  = round_mix(32'(r), hi);
                t  = hi;
                hi = lo ^ (f & mask);
                lo = t;
            end
            else
            begin
                f  = round_mix(32'(ROUND_COUNT - 1 - r), lo);
                t  = lo;
                lo = hi ^ (f & mask);
                hi = t;
            end
        end
        return (hi << hb) | lo;
    endfunction

    function automatic cwfp_rsp_t permute_index(input logic [IDX_W-1:0] idx,
                                                input logic inverse);
        logic [CNT_W-1:0]  n;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] x;
        longint unsigned   bound;
        longint unsigned   passes;
        int                bits;
        int                hb;
        cwfp_rsp_t         res;
        n = domain_reg;
        if (n == '0)
            n = CNT_W'(1);
        if (n > MAX_COUNT)
            n = MAX_COUNT;
        res.mapped_index = '0;
        res.domain_fault = 1'b0;
        if (idx >= n)
        begin
            res.domain_fault = 1'b1;
            res.mapped_index = IDX_W'(idx % n);
        end
        else if (n != CNT_W'(1))
        begin
            bits = 0;
            v    = 32'(n) - 32'd1;
            while (v != 0)
            begin
                v = v >> 1;
                bits++;
            end
            // Total width is rounded up to even, so each half is ceil(bits/2).
            hb     = (bits + 1) / 2;
            bound  = 64'd1 << (2 * hb);
            passes = 0;
            x      = 32'(idx);
            do
            begin
                x = feistel_pass(x, hb, inverse);
                passes++;
            end
            while (x >= n && passes < bound);
            if (x >= n)
            begin
                res.domain_fault = 1'b1;
                x = 32'(idx % n);
            end
            res.mapped_index = x[IDX_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_key   = '0;
            epoch_key  = '0;
            domain_reg = CNT_W'(1);
            expected_maps.delete();
            errors     = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Responses are handled before requests so that a transfer on both
            // channels at one edge pairs the response with the older request.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_maps.size() == 0)
                begin
                    if (errors < 10)
                        $display("[%0t] unexpected response: mapped_index %h domain_fault %b",
                                 $realtime, rsp_data.mapped_index, rsp_data.domain_fault);
                    errors++;
                end
                else
                begin
                    oldest_map = expected_maps.pop_front();
                    if (rsp_data.mapped_index !== oldest_map.mapped_index ||
                        rsp_data.domain_fault !== oldest_map.domain_fault)
                    begin
                        if (errors < 10)
                            $display({"[%0t] mismatch: mapped_index exp %h got %h, ",
                                      "domain_fault exp %b got %b"},
                                     $realtime, oldest_map.mapped_index,
                                     rsp_data.mapped_index, oldest_map.domain_fault,
                                     rsp_data.domain_fault);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_maps.push_back(permute_index(req_data.index, req_data.func));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEED:  seed_key   = cfg_data;
                    REG_EPOCH: epoch_key  = cfg_data;
                    REG_COUNT: domain_reg = cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
            pending    <= expected_maps.size();
            fail_count <= errors;
        end
    end

endmodule

FILE: tb/sv/cycle_walking_feistel_permutation_top_tb.sv
// ----------------------------------------------------------------------------
// cycle_walking_feistel_permutation_top_tb: stimulus and verdict
// Drives directed corner cases of the keyed permutation, then random phases
// of key, epoch and domain size with mostly in-range indexes, under random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module cycle_walking_feistel_permutation_top_tb;
    import cwfp_pkg::*;

    localparam logic                 FUNC_FWD      = 1'b0;
    localparam logic                 FUNC_INV      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam int                   TOTAL_ITEMS   = 1700;
    localparam int                   SETTLE_CYCLES = 40;
    localparam int                   CYCLE_LIMIT   = 2_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SEED;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    cwfp_req_t            req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    cwfp_rsp_t            rsp_data;

    int          fail_count;
    int          pending;
    int          cycle_count  = 0;
    int          stall_left   = 0;
    logic        calm         = 1'b0;
    int unsigned domain_now   = 1;
    int          items_sent   = 0;
    int          inverse_sent = 0;
    int          outside_sent = 0;
    int          settings     = 0;

    always #4 clk = ~clk;

    cycle_walking_feistel_permutation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    cycle_walking_feistel_permutation_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // No gap while calm; else mostly back to back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Valid is left high after a transfer; the next call lowers it only when a
    // gap is wanted, so it is never lowered and raised in the same step.
    task automatic send_request(input logic func, input logic [IDX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_data.func  <= func;
        req_data.index <= idx;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        items_sent++;
        if (func == FUNC_INV)
            inverse_sent++;
        if (32'(idx) >= domain_now)
            outside_sent++;
    endtask

    task automatic quiesce();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [WORD_W-1:0] seed, input logic [WORD_W-1:0] epoch,
                                 input logic [DATA_W-1:0] count_data);
        logic [CNT_W-1:0] n;
        quiesce();
        write_reg(REG_SEED, seed);
        write_reg(REG_EPOCH, epoch);
        write_reg(REG_COUNT, count_data);
        cfg_valid <= 1'b0;
        n = count_data[CNT_W-1:0];
        if (n == '0)
            n = CNT_W'(1);
        if (n > MAX_COUNT)
            n = MAX_COUNT;
        domain_now = 32'(n);
        settings++;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned       n;
        int                m;
        int                r;
        int                burst;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] epoch;
        logic [DATA_W-1:0] count_data;
        logic [IDX_W-1:0]  idx;
        logic              func;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset state: a domain of one, so only index zero is in range.
        send_request(FUNC_FWD, 24'h000000);
        send_request(FUNC_INV, 24'h000000);
        send_request(FUNC_FWD, 24'h000001);
        send_request(FUNC_INV, 24'hFFFFFF);

        // A write to the unused register index must change nothing.
        quiesce();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_request(FUNC_FWD, 24'h000000);
        send_request(FUNC_FWD, 24'h000007);

        // An item count of zero behaves as a domain of one.
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_FWD, 24'h000000);
        send_request(FUNC_INV, 24'h000003);

        apply_setting($urandom(), 32'h0000_0000, 32'd2);
        send_request(FUNC_FWD, 24'h000000);
        send_request(FUNC_FWD, 24'h000001);
        send_request(FUNC_INV, 24'h000001);
        send_request(FUNC_FWD, 24'h000002);

        // An oversized count is clamped to the full 24-bit domain.
        apply_setting(32'h0000_0000, $urandom(), 32'hFFFF_FFFF);
        send_request(FUNC_FWD, 24'h000000);
        send_request(FUNC_FWD, 24'hFFFFFF);
        send_request(FUNC_INV, 24'h000000);
        send_request(FUNC_INV, 24'hFFFFFF);

        // Odd bit widths round up, so these domains rely on cycle walking.
        apply_setting($urandom(), $urandom(), 32'd5);
        send_request(FUNC_FWD, 24'h000004);
        send_request(FUNC_INV, 24'h000004);
        send_request(FUNC_FWD, 24'h000005);
        send_request(FUNC_INV, 24'hFFFFFF);

        apply_setting($urandom(), $urandom(), 32'h0040_0001);
        send_request(FUNC_FWD, 24'h400000);
        send_request(FUNC_INV, 24'h000000);
        send_request(FUNC_FWD, 24'h400001);

        while (items_sent < TOTAL_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0: n = $urandom_range(1, 16);
                1: n = $urandom_range(17, 4096);
                2: n = $urandom_range(4097, MAX_ITEMS);
                3: n = 1 << (2 * $urandom_range(1, 12));
                4:
                begin
                    // Just above a power of four: most passes land out of range.
                    m = $urandom_range(1, 11);
                    n = (1 << (2 * m)) + $urandom_range(1, 3);
                end
                5: n = (1 << $urandom_range(1, 24)) - $urandom_range(0, 1);
                6: n = ($urandom_range(0, 1) != 0) ? 0 :
                       $urandom_range(MAX_ITEMS + 1, 32'h01FF_FFFF);
                default: n = $urandom_range(2, 64);
            endcase
            // The bits above the count field are don't-care on this register.
            count_data = {(($urandom_range(0, 1) != 0) ? 7'($urandom()) : 7'd0), 25'(n)};
            case ($urandom_range(0, 9))
                0: seed = 32'h0000_0000;
                1: seed = 32'hFFFF_FFFF;
                default: seed = $urandom();
            endcase
            case ($urandom_range(0, 9))
                0: epoch = 32'h0000_0000;
                1: epoch = 32'hFFFF_FFFF;
                default: epoch = $urandom();
            endcase
            apply_setting(seed, epoch, count_data);

            burst = $urandom_range(40, 120);
            repeat (burst)
            begin
                r = $urandom_range(0, 99);
                if (r < 84)
                    idx = IDX_W'($urandom_range(0, domain_now - 1));
                else if (r < 89)
                    idx = IDX_W'(domain_now - 1);
                else if (r < 92)
                    idx = '0;
                else
                    idx = IDX_W'($urandom());
                func = ($urandom_range(0, 1) != 0) ? FUNC_INV : FUNC_FWD;
                send_request(func, idx);
            end
        end

        quiesce();
        $display("Mapped %0d indexes (%0d inverse, %0d out of range) under %0d key and domain settings,",
                 items_sent, inverse_sent, outside_sent, settings);
        $display("with random request gaps and response stalls; %0d mismatches seen.", fail_count);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cwfp_pkg.sv
rtl/cycle_walking_feistel_permutation_top.sv
tb/sv/cycle_walking_feistel_permutation_checker.sv
tb/sv/cycle_walking_feistel_permutation_top_tb.sv
